@@ rtl/saf_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and state encodings for the seed adjacency filter
// no dependencies
package saf_pkg;

  localparam int unsigned COORD_DEPTH_DEF = 65536;
  localparam int unsigned MAX_KEYS_DEF    = 16;
  localparam int unsigned PREV_DEPTH_DEF  = 32;

  // bucket addresses: base (16 bits) plus size (16 bits)
  localparam int unsigned LW = 18;
  // signed target coordinate and compare width
  localparam int unsigned TW = 33;
  localparam int unsigned CW = 34;

  localparam logic [1:0] OP_WRITE_COORD = 2'd0;
  localparam logic [1:0] OP_WRITE_SLOT  = 2'd1;
  localparam logic [1:0] OP_START       = 2'd2;
  localparam logic [1:0] OP_CHECK       = 2'd3;

  localparam logic [1:0] REG_KEY_COUNT  = 2'd0;
  localparam logic [1:0] REG_MAX_MISSES = 2'd1;
  localparam logic [1:0] REG_INDEL_TOL  = 2'd2;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_PROBE, S_CMP, S_LAST, S_TOL, S_EMPTY
  } srch_state_t;

  typedef enum logic [2:0] {
    T_IDLE, T_SCAN, T_WALK, T_WAIT, T_FIN
  } top_state_t;

  typedef struct packed {
    logic                 start;
    logic [15:0]          base;
    logic [15:0]          size;
    logic signed [TW-1:0] target;
    logic [3:0]           tol;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_rsp_t;

endpackage

@@ rtl/seed_adjacency_filter.sv @@
`timescale 1ns / 1ps
// a check beat scans the accepted starts, then walks the key slots with one binary search
//   per searched slot; a duplicate start, too many misses or the early stop test ends it,
//   and the searches run one after another, since they all use the single coordinate
//   memory read port shared by all binary searches
// throughput: one check at a time, s_tready low while a check runs
// reset: synchronous rst clears control, registers to defaults, the start list count
module seed_adjacency_filter import saf_pkg::*; #(
  parameter int unsigned COORD_DEPTH = COORD_DEPTH_DEF,
  parameter int unsigned MAX_KEYS    = MAX_KEYS_DEF,
  parameter int unsigned PREV_DEPTH  = PREV_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // mem_addr, mem_data, key_slot, bucket_base, bucket_size, key_position,
  // candidate_coor, anchor_position, zero pad
  input  logic [127:0] s_tdata,
  // operation
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // skipped_duplicate, passed, miss_count, searches_done, zero pad
  output logic [15:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [5:0]   cfg_data
);

  localparam int unsigned KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned JW = $clog2(MAX_KEYS + 1);
  localparam int unsigned IW = (PREV_DEPTH > 1) ? $clog2(PREV_DEPTH) : 1;
  localparam int unsigned NW = $clog2(PREV_DEPTH + 1);

  // input fields
  logic [15:0] mem_addr, bucket_base, bucket_size;
  logic [30:0] mem_data, candidate_coor;
  logic [3:0]  key_slot, key_position, anchor_position;
  logic [1:0]  operation;
  assign operation       = s_tuser;
  assign mem_addr        = s_tdata[15:0];
  assign mem_data        = s_tdata[46:16];
  assign key_slot        = s_tdata[50:47];
  assign bucket_base     = s_tdata[66:51];
  assign bucket_size     = s_tdata[82:67];
  assign key_position    = s_tdata[86:83];
  assign candidate_coor  = s_tdata[117:87];
  assign anchor_position = s_tdata[121:118];

  // config registers
  logic [4:0] key_count;
  logic [3:0] max_misses, indel_tol;
  logic [5:0] seed_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count  <= 5'd8;
      max_misses <= 4'd2;
      indel_tol  <= 4'd3;
      seed_len   <= 6'd12;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KEY_COUNT:  key_count  <= cfg_data[4:0];
        REG_MAX_MISSES: max_misses <= cfg_data[3:0];
        REG_INDEL_TOL:  indel_tol  <= cfg_data[3:0];
        REG_KEY_LENGTH: seed_len   <= cfg_data;
        default: ;
      endcase
    end
  end

  // key slot descriptors, read at the walk index only
  logic [15:0] slot_base [MAX_KEYS];
  logic [15:0] slot_size [MAX_KEYS];
  logic [3:0]  slot_pos  [MAX_KEYS];
  // accepted read starts, scanned one per cycle
  logic signed [TW-1:0] starts [PREV_DEPTH];
  logic [NW-1:0] start_cnt;

  top_state_t state, state_next;
  logic s_beat, m_beat;
  logic [30:0] coor;
  logic [3:0]  anchor;
  logic signed [TW-1:0] read_start;
  logic [NW-1:0] scan_i;
  logic [JW-1:0] j;
  logic [5:0] misses, searches;
  logic [6:0] kc;
  logic signed [7:0] stop_lhs, stop_rhs;
  logic signed [CW-1:0] lo_win, hi_win, cand;
  logic signed [4:0] pos_diff;
  logic signed [11:0] offset;
  logic dup_hit, passing;
  srch_req_t req;
  srch_rsp_t rsp;
  logic [6:0] slot_ext;

  assign s_beat   = s_tvalid && s_tready;
  assign m_beat   = m_tvalid && m_tready;
  assign s_tready = (state == T_IDLE);
  assign slot_ext = 7'(key_slot);

  // key_count clamped to the number of slots
  assign kc = (7'(key_count) > 7'(MAX_KEYS)) ? 7'(MAX_KEYS) : 7'(key_count);

  always_ff @(posedge clk) begin
    if (s_beat && operation == OP_WRITE_SLOT && slot_ext < 7'(MAX_KEYS)) begin
      slot_base[KW'(slot_ext)] <= bucket_base;
      slot_size[KW'(slot_ext)] <= bucket_size;
      slot_pos[KW'(slot_ext)]  <= key_position;
    end
  end

  // duplicate window check on the entry under the scan pointer
  assign cand   = CW'(starts[IW'(scan_i)]);
  assign lo_win = CW'(read_start) - CW'(max_misses);
  assign hi_win = CW'(read_start) + CW'(max_misses);
  assign dup_hit = (cand > lo_win) && (cand < hi_win);

  // early stop: j - misses > kc - max_misses
  assign stop_lhs = 8'(j) - 8'(misses);
  assign stop_rhs = 8'(kc) - 8'(max_misses);

  // target of slot j, key spacing times position difference
  assign pos_diff = $signed({1'b0, slot_pos[KW'(j)]}) - $signed({1'b0, anchor});
  assign offset   = 12'(pos_diff) * 12'($signed({1'b0, seed_len}));

  always_comb begin
    req        = '0;
    req.base   = slot_base[KW'(j)];
    req.size   = slot_size[KW'(j)];
    req.target = TW'($signed({2'b00, coor})) + TW'(offset);
    req.tol    = indel_tol;
    req.start  = (state == T_WALK) && (7'(j) < kc) && !(stop_lhs > stop_rhs);
  end

  assign passing = (misses <= 6'(max_misses));

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE:  if (s_beat && operation == OP_CHECK) state_next = T_SCAN;
      T_SCAN: begin
        if (scan_i >= start_cnt) begin
          state_next = T_WALK;
        end else if (dup_hit) begin
          state_next = T_FIN;
        end
      end
      T_WALK:  state_next = req.start ? T_WAIT : T_FIN;
      T_WAIT: begin
        if (rsp.done) begin
          state_next = (!rsp.hit && misses + 6'd1 > 6'(max_misses)) ? T_FIN : T_WALK;
        end
      end
      T_FIN:   if (!m_tvalid || m_tready) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  logic skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      start_cnt <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (s_beat && operation == OP_START) start_cnt <= '0;
      // a new result beat replaces the one leaving in the same cycle
      if (state == T_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        if (!skip && passing && start_cnt < NW'(PREV_DEPTH)) begin
          start_cnt <= start_cnt + NW'(1);
        end
      end else if (m_beat) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        coor       <= candidate_coor;
        anchor     <= anchor_position;
        read_start <= TW'($signed({2'b00, candidate_coor}))
                      - TW'({6'd0, anchor_position} * {4'd0, seed_len});
        scan_i     <= '0;
        j          <= '0;
        misses     <= '0;
        searches   <= '0;
        skip       <= 1'b0;
      end
      T_SCAN: begin
        if (scan_i < start_cnt) begin
          if (dup_hit) skip <= 1'b1;
          scan_i <= scan_i + NW'(1);
        end
      end
      T_WALK: if (req.start) searches <= searches + 6'd1;
      T_WAIT: begin
        if (rsp.done) begin
          if (!rsp.hit) misses <= misses + 6'd1;
          j <= j + JW'(1);
        end
      end
      T_FIN: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= skip ? 16'd1 :
                     {4'd0, searches[4:0], misses[4:0], passing, 1'b0};
          if (!skip && passing && start_cnt < NW'(PREV_DEPTH)) begin
            starts[IW'(start_cnt)] <= read_start;
          end
        end
      end
      default: ;
    endcase
  end

  saf_search #(.COORD_DEPTH(COORD_DEPTH)) u_search (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s_beat && operation == OP_WRITE_COORD),
    .wr_addr (mem_addr),
    .wr_data (mem_data),
    .req     (req),
    .rsp     (rsp)
  );

  // a search is only started while none is outstanding
  a_single_search: assert property (@(posedge clk) disable iff (rst)
    req.start |=> !req.start) else $error("search restarted");
  // a skipped result carries no counts
  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[11:1] == '0) else $error("skip with counts");
  // misses never pass the searches
  a_miss_le_search: assert property (@(posedge clk) disable iff (rst)
    misses <= searches) else $error("misses exceed searches");
  // the start list never overflows
  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    start_cnt <= NW'(PREV_DEPTH)) else $error("start list overflow");

endmodule

@@ rtl/saf_search.sv @@
`timescale 1ns / 1ps
// coordinate memory and the shared binary search sequencer
// depends on saf_pkg
module saf_search import saf_pkg::*; #(
  parameter int unsigned COORD_DEPTH = COORD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] wr_addr,
  input  logic [30:0] wr_data,
  input  srch_req_t   req,
  output srch_rsp_t   rsp
);

  localparam int unsigned AW = $clog2(COORD_DEPTH);
  localparam int unsigned XW = (AW > LW) ? AW : LW;

  logic [30:0] mem [COORD_DEPTH];
  logic [30:0] rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  srch_state_t state, state_next;
  logic [LW-1:0] lo, hi, mid, lo_next, hi_next, mid_next;
  logic [LW-1:0] first, last, clamped, probe;
  logic signed [TW-1:0] target;
  logic [3:0] tol;
  logic signed [CW-1:0] v, t, tol_s;

  assign waddr = XW'(wr_addr) > 0 ? AW'(XW'(wr_addr)) : AW'(XW'(wr_addr));
  assign first = LW'(req.base) + LW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wr_data;
    end
    rdata <= mem[raddr];
  end

  // last probe lands inside the bucket
  assign clamped = (mid < first) ? first : ((mid > last) ? last : mid);
  assign probe = (state == S_LAST) ? clamped : mid;
  assign raddr = AW'(XW'(probe));

  assign v     = CW'($signed({1'b0, rdata}));
  assign t     = CW'(target);
  assign tol_s = CW'($signed({1'b0, tol}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    if (state == S_IDLE && req.start) begin
      target <= req.target;
      tol    <= req.tol;
      last   <= LW'(req.base) + LW'(req.size);
    end
  end

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    rsp        = '0;
    case (state)
      S_IDLE: begin
        if (req.start) begin
          lo_next  = first;
          hi_next  = LW'(req.base) + LW'(req.size);
          mid_next = first + LW'(req.size >> 1);
          state_next = (req.size == '0) ? S_EMPTY : S_PROBE;
        end
      end
      S_PROBE: begin
        state_next = (lo < hi) ? S_CMP : S_LAST;
      end
      S_CMP: begin
        if (v == t) begin
          state_next = S_LAST;
        end else begin
          if (v < t) begin
            lo_next = mid + LW'(1);
          end else begin
            hi_next = mid - LW'(1);
          end
          mid_next = (hi_next >= lo_next) ?
                     lo_next + ((hi_next - lo_next) >> 1) : lo_next;
          state_next = S_PROBE;
        end
      end
      S_LAST: begin
        state_next = S_TOL;
      end
      S_TOL: begin
        rsp.done = 1'b1;
        rsp.hit  = (v <= t + tol_s) && (v >= t - tol_s);
        state_next = S_IDLE;
      end
      S_EMPTY: begin
        rsp.done = 1'b1;
        rsp.hit  = 1'b0;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
